// ===== src/aesd_pkg.sv =====
// ----------------------------------------------------------------------------
// aesd_pkg: shared types, constants and AES inverse-cipher byte functions
// Inverse S-box table, GF(2^8) helpers and the front/back queue entry type.
// ----------------------------------------------------------------------------
`default_nettype none
package aesd_pkg;

  localparam int unsigned RoundsDefault = 10;
  localparam int unsigned StateBytes    = 16;
  localparam int unsigned BlockW        = 128;
  localparam int unsigned SlotW         = 4;

  typedef enum logic {
    CMD_LOAD_KEY = 1'b0,
    CMD_DECRYPT  = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [BlockW-1:0] block;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ROUND,
    BK_DONE
  } back_state_e;

  function automatic logic [7:0] inv_sub_byte(input logic [7:0] a);
    logic [7:0] r;
    case (a)
      8'h00: r=8'h52; 8'h01: r=8'h09; 8'h02: r=8'h6a; 8'h03: r=8'hd5;
      8'h04: r=8'h30; 8'h05: r=8'h36; 8'h06: r=8'ha5; 8'h07: r=8'h38;
      8'h08: r=8'hbf; 8'h09: r=8'h40; 8'h0a: r=8'ha3; 8'h0b: r=8'h9e;
      8'h0c: r=8'h81; 8'h0d: r=8'hf3; 8'h0e: r=8'hd7; 8'h0f: r=8'hfb;
      8'h10: r=8'h7c; 8'h11: r=8'he3; 8'h12: r=8'h39; 8'h13: r=8'h82;
      8'h14: r=8'h9b; 8'h15: r=8'h2f; 8'h16: r=8'hff; 8'h17: r=8'h87;
      8'h18: r=8'h34; 8'h19: r=8'h8e; 8'h1a: r=8'h43; 8'h1b: r=8'h44;
      8'h1c: r=8'hc4; 8'h1d: r=8'hde; 8'h1e: r=8'he9; 8'h1f: r=8'hcb;
      8'h20: r=8'h54; 8'h21: r=8'h7b; 8'h22: r=8'h94; 8'h23: r=8'h32;
      8'h24: r=8'ha6; 8'h25: r=8'hc2; 8'h26: r=8'h23; 8'h27: r=8'h3d;
      8'h28: r=8'hee; 8'h29: r=8'h4c; 8'h2a: r=8'h95; 8'h2b: r=8'h0b;
      8'h2c: r=8'h42; 8'h2d: r=8'hfa; 8'h2e: r=8'hc3; 8'h2f: r=8'h4e;
      8'h30: r=8'h08; 8'h31: r=8'h2e; 8'h32: r=8'ha1; 8'h33: r=8'h66;
      8'h34: r=8'h28; 8'h35: r=8'hd9; 8'h36: r=8'h24; 8'h37: r=8'hb2;
      8'h38: r=8'h76; 8'h39: r=8'h5b; 8'h3a: r=8'ha2; 8'h3b: r=8'h49;
      8'h3c: r=8'h6d; 8'h3d: r=8'h8b; 8'h3e: r=8'hd1; 8'h3f: r=8'h25;
      8'h40: r=8'h72; 8'h41: r=8'hf8; 8'h42: r=8'hf6; 8'h43: r=8'h64;
      8'h44: r=8'h86; 8'h45: r=8'h68; 8'h46: r=8'h98; 8'h47: r=8'h16;
      8'h48: r=8'hd4; 8'h49: r=8'ha4; 8'h4a: r=8'h5c; 8'h4b: r=8'hcc;
      8'h4c: r=8'h5d; 8'h4d: r=8'h65; 8'h4e: r=8'hb6; 8'h4f: r=8'h92;
      8'h50: r=8'h6c; 8'h51: r=8'h70; 8'h52: r=8'h48; 8'h53: r=8'h50;
      8'h54: r=8'hfd; 8'h55: r=8'hed; 8'h56: r=8'hb9; 8'h57: r=8'hda;
      8'h58: r=8'h5e; 8'h59: r=8'h15; 8'h5a: r=8'h46; 8'h5b: r=8'h57;
      8'h5c: r=8'ha7; 8'h5d: r=8'h8d; 8'h5e: r=8'h9d; 8'h5f: r=8'h84;
      8'h60: r=8'h90; 8'h61: r=8'hd8; 8'h62: r=8'hab; 8'h63: r=8'h00;
      8'h64: r=8'h8c; 8'h65: r=8'hbc; 8'h66: r=8'hd3; 8'h67: r=8'h0a;
      8'h68: r=8'hf7; 8'h69: r=8'he4; 8'h6a: r=8'h58; 8'h6b: r=8'h05;
      8'h6c: r=8'hb8; 8'h6d: r=8'hb3; 8'h6e: r=8'h45; 8'h6f: r=8'h06;
      8'h70: r=8'hd0; 8'h71: r=8'h2c; 8'h72: r=8'h1e; 8'h73: r=8'h8f;
      8'h74: r=8'hca; 8'h75: r=8'h3f; 8'h76: r=8'h0f; 8'h77: r=8'h02;
      8'h78: r=8'hc1; 8'h79: r=8'haf; 8'h7a: r=8'hbd; 8'h7b: r=8'h03;
      8'h7c: r=8'h01; 8'h7d: r=8'h13; 8'h7e: r=8'h8a; 8'h7f: r=8'h6b;
      8'h80: r=8'h3a; 8'h81: r=8'h91; 8'h82: r=8'h11; 8'h83: r=8'h41;
      8'h84: r=8'h4f; 8'h85: r=8'h67; 8'h86: r=8'hdc; 8'h87: r=8'hea;
      8'h88: r=8'h97; 8'h89: r=8'hf2; 8'h8a: r=8'hcf; 8'h8b: r=8'hce;
      8'h8c: r=8'hf0; 8'h8d: r=8'hb4; 8'h8e: r=8'he6; 8'h8f: r=8'h73;
      8'h90: r=8'h96; 8'h91: r=8'hac; 8'h92: r=8'h74; 8'h93: r=8'h22;
      8'h94: r=8'he7; 8'h95: r=8'had; 8'h96: r=8'h35; 8'h97: r=8'h85;
      8'h98: r=8'he2; 8'h99: r=8'hf9; 8'h9a: r=8'h37; 8'h9b: r=8'he8;
      8'h9c: r=8'h1c; 8'h9d: r=8'h75; 8'h9e: r=8'hdf; 8'h9f: r=8'h6e;
      8'ha0: r=8'h47; 8'ha1: r=8'hf1; 8'ha2: r=8'h1a; 8'ha3: r=8'h71;
      8'ha4: r=8'h1d; 8'ha5: r=8'h29; 8'ha6: r=8'hc5; 8'ha7: r=8'h89;
      8'ha8: r=8'h6f; 8'ha9: r=8'hb7; 8'haa: r=8'h62; 8'hab: r=8'h0e;
      8'hac: r=8'haa; 8'had: r=8'h18; 8'hae: r=8'hbe; 8'haf: r=8'h1b;
      8'hb0: r=8'hfc; 8'hb1: r=8'h56; 8'hb2: r=8'h3e; 8'hb3: r=8'h4b;
      8'hb4: r=8'hc6; 8'hb5: r=8'hd2; 8'hb6: r=8'h79; 8'hb7: r=8'h20;
      8'hb8: r=8'h9a; 8'hb9: r=8'hdb; 8'hba: r=8'hc0; 8'hbb: r=8'hfe;
      8'hbc: r=8'h78; 8'hbd: r=8'hcd; 8'hbe: r=8'h5a; 8'hbf: r=8'hf4;
      8'hc0: r=8'h1f; 8'hc1: r=8'hdd; 8'hc2: r=8'ha8; 8'hc3: r=8'h33;
      8'hc4: r=8'h88; 8'hc5: r=8'h07; 8'hc6: r=8'hc7; 8'hc7: r=8'h31;
      8'hc8: r=8'hb1; 8'hc9: r=8'h12; 8'hca: r=8'h10; 8'hcb: r=8'h59;
      8'hcc: r=8'h27; 8'hcd: r=8'h80; 8'hce: r=8'hec; 8'hcf: r=8'h5f;
      8'hd0: r=8'h60; 8'hd1: r=8'h51; 8'hd2: r=8'h7f; 8'hd3: r=8'ha9;
      8'hd4: r=8'h19; 8'hd5: r=8'hb5; 8'hd6: r=8'h4a; 8'hd7: r=8'h0d;
      8'hd8: r=8'h2d; 8'hd9: r=8'he5; 8'hda: r=8'h7a; 8'hdb: r=8'h9f;
      8'hdc: r=8'h93; 8'hdd: r=8'hc9; 8'hde: r=8'h9c; 8'hdf: r=8'hef;
      8'he0: r=8'ha0; 8'he1: r=8'he0; 8'he2: r=8'h3b; 8'he3: r=8'h4d;
      8'he4: r=8'hae; 8'he5: r=8'h2a; 8'he6: r=8'hf5; 8'he7: r=8'hb0;
      8'he8: r=8'hc8; 8'he9: r=8'heb; 8'hea: r=8'hbb; 8'heb: r=8'h3c;
      8'hec: r=8'h83; 8'hed: r=8'h53; 8'hee: r=8'h99; 8'hef: r=8'h61;
      8'hf0: r=8'h17; 8'hf1: r=8'h2b; 8'hf2: r=8'h04; 8'hf3: r=8'h7e;
      8'hf4: r=8'hba; 8'hf5: r=8'h77; 8'hf6: r=8'hd6; 8'hf7: r=8'h26;
      8'hf8: r=8'he1; 8'hf9: r=8'h69; 8'hfa: r=8'h14; 8'hfb: r=8'h63;
      8'hfc: r=8'h55; 8'hfd: r=8'h21; 8'hfe: r=8'h0c; 8'hff: r=8'h7d;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte index b = 4*c+r; byte 0 sits in bits [127:120].
  function automatic logic [7:0] get_b(input logic [BlockW-1:0] s, input int b);
    return s[BlockW-1-8*b -: 8];
  endfunction

  // One round body: InvShiftRows, InvSubBytes, AddRoundKey, optional InvMixColumns.
  function automatic logic [BlockW-1:0] inv_round(input logic [BlockW-1:0] s,
                                                  input logic [BlockW-1:0] k,
                                                  input logic mix);
    logic [BlockW-1:0] t;
    logic [BlockW-1:0] m;
    logic [7:0] a0, a1, a2, a3, d0, d1, d2, d3, q0, q1, q2, q3;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[BlockW-1-8*(4*c+r) -: 8] = inv_sub_byte(get_b(s, 4*((c-r+4)%4)+r));
      end
    end
    t = t ^ k;
    for (int c = 0; c < 4; c++) begin
      a0 = get_b(t, 4*c);   a1 = get_b(t, 4*c+1);
      a2 = get_b(t, 4*c+2); a3 = get_b(t, 4*c+3);
      d0 = xt(a0); d1 = xt(a1); d2 = xt(a2); d3 = xt(a3);
      q0 = xt(d0); q1 = xt(d1); q2 = xt(d2); q3 = xt(d3);
      // 9=8+1, 11=8+2+1, 13=8+4+1, 14=8+4+2
      m[BlockW-1-8*(4*c)   -: 8] = (xt(q0)^q0^d0) ^ (xt(q1)^d1^a1) ^ (xt(q2)^q2^a2) ^ (xt(q3)^a3);
      m[BlockW-1-8*(4*c+1) -: 8] = (xt(q0)^a0) ^ (xt(q1)^q1^d1) ^ (xt(q2)^d2^a2) ^ (xt(q3)^q3^a3);
      m[BlockW-1-8*(4*c+2) -: 8] = (xt(q0)^q0^a0) ^ (xt(q1)^a1) ^ (xt(q2)^q2^d2) ^ (xt(q3)^d3^a3);
      m[BlockW-1-8*(4*c+3) -: 8] = (xt(q0)^d0^a0) ^ (xt(q1)^q1^a1) ^ (xt(q2)^a2) ^ (xt(q3)^q3^d3);
    end
    return mix ? m : t;
  endfunction

endpackage
`default_nettype wire

// ===== src/aes128_block_decrypt.sv =====
// ----------------------------------------------------------------------------
// aes128_block_decrypt: AES inverse cipher with software-loaded round keys
// Front decode, two-entry job queue, iterative round engine.
// ----------------------------------------------------------------------------
//  channel  | direction | transfer carries
//  s_axis   | in        | tuser=cmd, tdata={word_low,word_high,key_slot}
//  m_axis   | out       | tdata={plain_low,plain_high}
//
// A decrypt block that leaves the queue passes through the round engine (one key
// XOR, Rounds rounds, then the result held until taken) and the idle state before
// the next pop, so the engine takes no new block until it is through with the last;
// set by the single shared round unit and the one read port of the key store.
// Load items stall while any block is queued or in its rounds, so each block uses
// the keys loaded before it; with nothing in flight they are taken every cycle.
// Reset clears the control only; key store contents are undefined until loaded.
// The queue holds two blocks, so the input takes up to two more blocks while a
// result stalls.
`default_nettype none
module aes128_block_decrypt import aesd_pkg::*; #(
  parameter int unsigned ROUNDS = RoundsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [135:0] s_axis_tdata,  // key_slot[3:0], word_high[67:4], word_low[131:68]
  input  logic [0:0]   s_axis_tuser,  // cmd[0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata   // plain_high[63:0], plain_low[127:64]
);
  localparam int unsigned KeyAw = $clog2(ROUNDS+1);

  logic q_full, q_push, q_pop, q_valid, kw_en, eng_busy, key_hold;
  job_t q_in, q_out;
  logic [KeyAw-1:0]  kw_addr;
  logic [BlockW-1:0] kw_data, res;

  // keys must stay put while a block waits in the queue or runs its rounds
  assign key_hold = q_valid || eng_busy;

  aesd_front #(.Rounds(ROUNDS)) u_front (
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .cmd_i(s_axis_tuser[0]), .slot_i(s_axis_tdata[3:0]),
    .data_i({s_axis_tdata[67:4], s_axis_tdata[131:68]}),
    .q_full_i(q_full), .key_hold_i(key_hold), .q_push_o(q_push), .q_job_o(q_in),
    .kw_en_o(kw_en), .kw_addr_o(kw_addr), .kw_data_o(kw_data)
  );

  aesd_queue u_queue (
    .clk_i, .rst_ni, .push_i(q_push), .job_i(q_in), .full_o(q_full),
    .pop_i(q_pop), .valid_o(q_valid), .job_o(q_out)
  );

  aesd_back #(.Rounds(ROUNDS)) u_back (
    .clk_i, .rst_ni, .kw_en_i(kw_en), .kw_addr_i(kw_addr), .kw_data_i(kw_data),
    .q_valid_i(q_valid), .q_job_i(q_out), .q_pop_o(q_pop), .busy_o(eng_busy),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_data_o(res)
  );

  // high half of the state is plain_high, lowest in tdata
  assign m_axis_tdata = {res[63:0], res[127:64]};
endmodule
`default_nettype wire

// ===== src/aesd_front.sv =====
// ----------------------------------------------------------------------------
// aesd_front: command decode and key store write
// Load items write the key store; decrypt items go into the job queue.
// ----------------------------------------------------------------------------
`default_nettype none
module aesd_front import aesd_pkg::*; #(
  parameter int unsigned Rounds = RoundsDefault
) (
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              cmd_i,
  input  logic [SlotW-1:0]  slot_i,
  input  logic [BlockW-1:0] data_i,
  input  logic              q_full_i,
  input  logic              key_hold_i,
  output logic              q_push_o,
  output job_t              q_job_o,
  output logic              kw_en_o,
  output logic [$clog2(Rounds+1)-1:0] kw_addr_o,
  output logic [BlockW-1:0] kw_data_o
);
  logic is_dec;
  assign is_dec     = (cmd_i == CMD_DECRYPT);
  // hold loads while a block still needs the keys; decrypt waits for queue room
  assign in_ready_o = is_dec ? !q_full_i : !key_hold_i;
  assign q_push_o   = in_valid_i && in_ready_o && is_dec;
  assign q_job_o    = '{block: data_i};
  assign kw_en_o    = in_valid_i && in_ready_o && !is_dec &&
                      ({28'd0, slot_i} <= 32'(Rounds));
  assign kw_addr_o  = slot_i[$clog2(Rounds+1)-1:0];
  assign kw_data_o  = data_i;
endmodule
`default_nettype wire

// ===== src/aesd_queue.sv =====
// ----------------------------------------------------------------------------
// aesd_queue: two-entry job queue
// Decouples decode from the iterative round engine.
// ----------------------------------------------------------------------------
`default_nettype none
module aesd_queue import aesd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t job_o
);
  job_t      mem_q [2];
  logic      wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign job_o   = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= job_i;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i || pop_i) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("queue underflow");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2) else $error("queue count out of range");
`endif
endmodule
`default_nettype wire

// ===== src/aesd_back.sv =====
// ----------------------------------------------------------------------------
// aesd_back: iterative round engine with key store and output register
// One round per cycle through a shared round unit.
// ----------------------------------------------------------------------------
`default_nettype none
module aesd_back import aesd_pkg::*; #(
  parameter int unsigned Rounds = RoundsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              kw_en_i,
  input  logic [$clog2(Rounds+1)-1:0] kw_addr_i,
  input  logic [BlockW-1:0] kw_data_i,
  input  logic              q_valid_i,
  input  job_t              q_job_i,
  output logic              q_pop_o,
  output logic              busy_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [BlockW-1:0] out_data_o
);
  localparam int unsigned KeyAw = $clog2(Rounds+1);

  logic [BlockW-1:0] keys_q [Rounds+1];
  back_state_e       st_q, st_d;
  logic [KeyAw-1:0]  rnd_q, rnd_d;
  logic [BlockW-1:0] s_q, s_d;
  logic [BlockW-1:0] k_q;
  logic [KeyAw-1:0]  rd_addr;

  // key store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (kw_en_i) keys_q[kw_addr_i] <= kw_data_i;
    k_q <= keys_q[rd_addr];
  end

  assign q_pop_o     = (st_q == BK_IDLE) && q_valid_i;
  assign busy_o      = (st_q == BK_ROUND);
  assign out_valid_o = (st_q == BK_DONE);
  assign out_data_o  = s_q;

  always_comb begin
    st_d = st_q;
    case (st_q)
      BK_IDLE:  if (q_valid_i) st_d = BK_ROUND;
      BK_ROUND: if (rnd_q == '0) st_d = BK_DONE;
      BK_DONE:  if (out_ready_i) st_d = BK_IDLE;
      default:  st_d = BK_IDLE;
    endcase
  end

  // rnd_q counts the key already read: the key for round rnd_q is in k_q
  always_comb begin
    rnd_d   = rnd_q;
    s_d     = s_q;
    rd_addr = KeyAw'(Rounds);
    case (st_q)
      BK_IDLE: begin
        rnd_d   = KeyAw'(Rounds);
        s_d     = q_job_i.block;
        rd_addr = KeyAw'(Rounds);
      end
      BK_ROUND: begin
        if (rnd_q == KeyAw'(Rounds)) s_d = s_q ^ k_q;
        else s_d = inv_round(s_q, k_q, rnd_q != '0);
        rnd_d   = rnd_q - 1'b1;
        rd_addr = (rnd_q == '0) ? '0 : rnd_q - 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= BK_IDLE;
      rnd_q <= '0;
    end else begin
      st_q  <= st_d;
      rnd_q <= rnd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q != BK_DONE) s_q <= s_d;
  end

`ifndef SYNTHESIS
  a_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped under stall");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> st_q == BK_ROUND && rnd_q == KeyAw'(Rounds))
    else $error("job start mismatch");
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == BK_ROUND && rnd_q == '0 |=> out_valid_o) else $error("missing result");
  a_key_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kw_en_i |-> st_q != BK_ROUND) else $error("key written during rounds");
`endif
endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the AES-128 block decrypt unit
// Loads round keys, decrypts directed and random blocks under random stalls on
// both streams, checks each plaintext against a known answer or in-bench inverse cipher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_top;
  import aesd_pkg::*;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata = '0;
  logic [0:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;

  aes128_block_decrypt DUT (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always #5 clk_i = ~clk_i;

  typedef struct {
    cmd_e        cmd;
    logic [3:0]  slot;
    logic [63:0] hi;
    logic [63:0] lo;
    bit          has_plain;
    logic [127:0] plain;
  } op_t;

  logic [127:0] key_bank [0:10];
  logic [7:0]   inv_tab [0:255];
  logic [127:0] plain_q [$];
  int           errors = 0;
  bit           quiet = 0;

  function automatic logic [7:0] gf_dbl(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] acc;
    acc = 0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = gf_dbl(a);
    end
    return acc;
  endfunction

  // Build the inverse S-box from the field inverse and the affine map.
  task automatic build_inv_tab();
    logic [7:0] v, s;
    for (int x = 0; x < 256; x++) begin
      v = 1;
      for (int k = 0; k < 254; k++) v = gf_mul(v, x[7:0]);
      if (x == 0) v = 0;
      s = v ^ {v[6:0], v[7]} ^ {v[5:0], v[7:6]} ^ {v[4:0], v[7:5]} ^ {v[3:0], v[7:4]}
          ^ 8'h63;
      inv_tab[s] = x[7:0];
    end
  endtask

  function automatic logic [127:0] decrypt_block(logic [127:0] blk);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3;
    logic [127:0] r;
    blk ^= key_bank[10];
    for (int i = 0; i < 16; i++) s[i] = blk[127-8*i -: 8];
    for (int rd = 9; rd >= 0; rd--) begin
      t = s;
      for (int c = 0; c < 4; c++)
        for (int w = 0; w < 4; w++)
          s[4*c+w] = inv_tab[t[4*((c-w+4)%4)+w]] ^ key_bank[rd][127-8*(4*c+w) -: 8];
      if (rd != 0)
        for (int c = 0; c < 4; c++) begin
          a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
          s[4*c]   = gf_mul(a0,14) ^ gf_mul(a1,11) ^ gf_mul(a2,13) ^ gf_mul(a3,9);
          s[4*c+1] = gf_mul(a0,9)  ^ gf_mul(a1,14) ^ gf_mul(a2,11) ^ gf_mul(a3,13);
          s[4*c+2] = gf_mul(a0,13) ^ gf_mul(a1,9)  ^ gf_mul(a2,14) ^ gf_mul(a3,11);
          s[4*c+3] = gf_mul(a0,11) ^ gf_mul(a1,13) ^ gf_mul(a2,9)  ^ gf_mul(a3,14);
        end
    end
    for (int i = 0; i < 16; i++) r[127-8*i -: 8] = s[i];
    return r;
  endfunction

  // Drive one transfer; update the key copy or queue the expected plaintext.
  task automatic send(op_t op);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op.cmd;
    s_axis_tdata  <= {4'h0, op.lo, op.hi, op.slot};
    do @(posedge clk_i); while (!s_axis_tready);
    if (op.cmd == CMD_LOAD_KEY) begin
      if (op.slot <= 10) key_bank[op.slot] = {op.hi, op.lo};
    end else begin
      plain_q.push_back(op.has_plain ? op.plain : decrypt_block({op.hi, op.lo}));
    end
    @(negedge clk_i);
  endtask

  // Receiver: random stall bursts, compare each transfer with the oldest expectation.
  initial begin
    int hold;
    logic [127:0] want;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!quiet && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        hold = $urandom_range(1, 18);
        repeat (hold) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        if (plain_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %h", m_axis_tdata);
        end else begin
          want = plain_q.pop_front();
          if ({m_axis_tdata[63:0], m_axis_tdata[127:64]} !== want) begin
            errors++;
            if (errors <= 10)
              $display("plain mismatch: exp hi %h lo %h, got hi %h lo %h",
                       want[127:64], want[63:0], m_axis_tdata[63:0], m_axis_tdata[127:64]);
          end
        end
      end
    end
  end

  initial begin
    #50ms;
    $display("Test completed with failures");
    $finish;
  end

  // FIPS-197 example key schedule, round key 0 first.
  localparam logic [127:0] FipsKeys [0:10] = '{
    128'h000102030405060708090a0b0c0d0e0f, 128'hd6aa74fdd2af72fadaa678f1d6ab76fe,
    128'hb692cf0b643dbdf1be9bc5006830b3fe, 128'hb6ff744ed2c2c9bf6c590cbf0469bf41,
    128'h47f7f7bc95353e03f96c32bcfd058dfd, 128'h3caaa3e8a99f9deb50f3af57adf622aa,
    128'h5e390f7df7a69296a7553dc10aa31f6b, 128'h14f9701ae35fe28c440adf4d4ea9c026,
    128'h47438735a41c65b9e016baf4aebf7ad2, 128'h549932d1f08557681093ed9cbe2c974e,
    128'h13111d7fe3944a17f307a78b4d2b30c5};

  initial begin
    op_t dir [$];
    op_t op;
    int n;
    build_inv_tab();
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    for (int k = 0; k <= 10; k++)
      dir.push_back('{CMD_LOAD_KEY, k[3:0], FipsKeys[k][127:64], FipsKeys[k][63:0], 0, 0});
    // Known answer for the standard example block.
    dir.push_back('{CMD_DECRYPT, 4'hf, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1,
                    128'h00112233445566778899aabbccddeeff});
    // Out-of-range slots are dropped and must not disturb the keys.
    dir.push_back('{CMD_LOAD_KEY, 4'hb, '1, '1, 0, 0});
    dir.push_back('{CMD_LOAD_KEY, 4'hf, '1, 64'h0, 0, 0});
    dir.push_back('{CMD_DECRYPT, 4'h0, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1,
                    128'h00112233445566778899aabbccddeeff});
    dir.push_back('{CMD_DECRYPT, 4'h5, 64'h0, 64'h0, 0, 0});
    dir.push_back('{CMD_DECRYPT, 4'ha, '1, '1, 0, 0});
    // All-zero keys: decrypt of zero block against a zero schedule.
    for (int k = 0; k <= 10; k++) dir.push_back('{CMD_LOAD_KEY, k[3:0], 0, 0, 0, 0});
    dir.push_back('{CMD_DECRYPT, 4'h0, 64'h0, 64'h0, 0, 0});
    foreach (dir[i]) send(dir[i]);

    for (int i = 0; i < 900; i++) begin
      if (i == 780) quiet = 1;
      n = $urandom_range(0, 99);
      op.has_plain = 0;
      op.plain = 0;
      op.hi = {$urandom, $urandom};
      op.lo = {$urandom, $urandom};
      op.slot = (n < 5) ? 4'($urandom_range(11, 15)) : 4'($urandom_range(0, 10));
      op.cmd = (n < 25) ? CMD_LOAD_KEY : CMD_DECRYPT;
      if (n >= 95) begin
        op.hi = (n & 1) ? '1 : '0;
        op.lo = (n & 2) ? '1 : '0;
      end
      send(op);
    end
    s_axis_tvalid <= 1'b0;

    n = 0;
    while (plain_q.size() != 0 && n < 100000) begin
      @(posedge clk_i);
      n++;
    end
    repeat (40) @(posedge clk_i);
    if (errors == 0 && plain_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// ===== files.f =====
src/aesd_pkg.sv
src/aesd_front.sv
src/aesd_queue.sv
src/aesd_back.sv
src/aes128_block_decrypt.sv
tb/sv/tb_top.sv
